// ===== rtl/lms_phrase_segmenter_defines.svh =====
// ----------------------------------------------------------------------------
// LMS phrase segmenter assertion macros
// Shared property wrappers for the checker, clocked on posedge, reset-disabled.
// ----------------------------------------------------------------------------
`ifndef LMS_PHRASE_SEGMENTER_DEFINES_SVH
`define LMS_PHRASE_SEGMENTER_DEFINES_SVH

// Same-cycle implication.
`define LMSPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lmsps same-cycle check failed");

// Next-cycle implication.
`define LMSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lmsps next-cycle check failed");

`endif

// ===== rtl/lmsps_pkg.sv =====
// ----------------------------------------------------------------------------
// lmsps_pkg
// Types and slot codes shared by the LMS phrase segmenter modules.
// ----------------------------------------------------------------------------
package lmsps_pkg;

	localparam int SymW = 32;

	// Result slots of one item, in issue order.
	localparam int NumSlots      = 5;
	localparam int SlotCutEnd    = 0; // end marker before held symbol (LMS cut)
	localparam int SlotHeld      = 1; // previously held symbol
	localparam int SlotSepEnd    = 2; // end marker after held symbol (separator)
	localparam int SlotNew       = 3; // this item's symbol on range flush
	localparam int SlotFlushEnd  = 4; // end marker closing the range

	typedef logic [NumSlots-1:0] slot_mask_t;

	typedef struct packed {
		logic [SymW-1:0] symbol;
		logic            is_separator;
		logic            last_of_range;
		logic            before_is_boundary;
	} item_t;

	typedef struct packed {
		logic [SymW-1:0] phrase_symbol;
		logic            phrase_end;
		logic            last;
	} result_t;

	typedef struct packed {
		logic started;
		logic held_is_separator;
		logic held_is_s_type;
		logic phrase_has_output;
	} seg_flags_t;

	localparam seg_flags_t FlagsReset = '{
		started:           1'b0,
		held_is_separator: 1'b0,
		held_is_s_type:    1'b1,
		phrase_has_output: 1'b0
	};

endpackage

// ===== rtl/lms_phrase_segmenter.sv =====
// ----------------------------------------------------------------------------
// lms_phrase_segmenter
// Cuts a reverse-order symbol stream into LMS phrases plus end markers.
// ----------------------------------------------------------------------------
// The first result of an item, if any, is offered the cycle after it is taken.
// Throughput: one item per cycle while each item yields at most one result
//   and result_ready is high; an item yielding k results (k up to 4) holds
//   the result register, draining one result per cycle while result_ready is
//   high, until all k leave; the next item is taken in the cycle the last leaves.
// Reset (arst_n low, async): no results pending, a new range, drop mode off.
// ----------------------------------------------------------------------------
module lms_phrase_segmenter #(
	parameter int SYMBOL_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	// input symbols
	input  logic              item_valid,
	output logic              item_ready,
	input  lmsps_pkg::item_t  item,
	// phrase results
	output logic              result_valid,
	input  logic              result_ready,
	output lmsps_pkg::result_t result,
	// configuration: drop_lone_separator
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_data
);
	import lmsps_pkg::*;

	// Symbol bits that matter; the port is SymW wide.
	localparam int HeldBits = (SYMBOL_BITS < SymW) ? SYMBOL_BITS : SymW;

	// Segmenter state: the held symbol waits one item until we know
	// whether a cut lands in front of it.
	logic [HeldBits-1:0] held_symbol_q;
	seg_flags_t          flags_q;
	logic                drop_q;

	// Result register: the two candidate symbols of the last item plus a
	// mask of which of the five slots still have to be issued.
	logic [HeldBits-1:0] held_sym_s1;
	logic [HeldBits-1:0] new_sym_s1;
	slot_mask_t          pend_q;

	logic [HeldBits-1:0] next_held_symbol;
	seg_flags_t          next_flags;
	slot_mask_t          slots_new;
	slot_mask_t          cur_slot;
	logic                is_final;
	logic                item_take;
	logic                result_take;

	assign cfg_ready = 1'b1;

	lmsps_classify #(
		.HeldBits(HeldBits)
	) u_classify (
		.held_symbol        (held_symbol_q),
		.flags              (flags_q),
		.symbol             (item.symbol[HeldBits-1:0]),
		.is_separator       (item.is_separator),
		.last_of_range      (item.last_of_range),
		.before_is_boundary (item.before_is_boundary),
		.drop_lone_separator(drop_q),
		.next_held_symbol   (next_held_symbol),
		.next_flags         (next_flags),
		.slots              (slots_new)
	);

	// Lowest pending slot is the one on show; it is the item's last
	// result when no other slot remains behind it.
	assign cur_slot     = pend_q & (~pend_q + slot_mask_t'(1));
	assign is_final     = (pend_q & ~cur_slot) == '0;
	assign result_valid = pend_q != '0;
	assign result_take  = result_valid && result_ready;

	// Take a new item once the pending results are gone or the last one
	// leaves in this very transaction.
	assign item_ready = (pend_q == '0) || (result_ready && is_final);
	assign item_take  = item_valid && item_ready;

	always_comb begin
		result.phrase_end    = cur_slot[SlotCutEnd] | cur_slot[SlotSepEnd]
			| cur_slot[SlotFlushEnd];
		result.last          = is_final;
		result.phrase_symbol = '0;
		if (cur_slot[SlotHeld]) begin
			result.phrase_symbol = SymW'(held_sym_s1);
		end else if (cur_slot[SlotNew]) begin
			result.phrase_symbol = SymW'(new_sym_s1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drop_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			drop_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= FlagsReset;
			held_symbol_q <= '0;
			pend_q        <= '0;
		end else if (item_take) begin
			flags_q       <= next_flags;
			held_symbol_q <= next_held_symbol;
			pend_q        <= slots_new;
		end else if (result_take) begin
			pend_q        <= pend_q & ~cur_slot;
		end
	end

	// Payload only, no reset.
	always_ff @(posedge clk) begin
		if (item_take) begin
			held_sym_s1 <= held_symbol_q;
			new_sym_s1  <= item.symbol[HeldBits-1:0];
		end
	end

endmodule

// ===== rtl/lmsps_classify.sv =====
// ----------------------------------------------------------------------------
// lmsps_classify
// S/L typing of one symbol, cut decisions and next segmenter state.
// ----------------------------------------------------------------------------
module lmsps_classify #(
	parameter int HeldBits = 32
) (
	input  logic [HeldBits-1:0]  held_symbol,
	input  lmsps_pkg::seg_flags_t flags,
	input  logic [HeldBits-1:0]  symbol,
	input  logic                 is_separator,
	input  logic                 last_of_range,
	input  logic                 before_is_boundary,
	input  logic                 drop_lone_separator,
	output logic [HeldBits-1:0]  next_held_symbol,
	output lmsps_pkg::seg_flags_t next_flags,
	output lmsps_pkg::slot_mask_t slots
);
	import lmsps_pkg::*;

	logic sym_lt, sym_eq, lone_mid, lone_end, s_type;
	seg_flags_t mid_flags;
	slot_mask_t mid_slots;

	assign sym_lt   = symbol < held_symbol;
	assign sym_eq   = symbol == held_symbol;
	assign lone_mid = drop_lone_separator && !flags.phrase_has_output && flags.held_is_separator;
	assign s_type   = sym_lt ? 1'b1 : (sym_eq ? flags.held_is_s_type : 1'b0);

	always_comb begin
		mid_slots = '0;
		mid_flags = flags;
		if (!flags.started) begin
			mid_flags.started           = 1'b1;
			mid_flags.held_is_separator = is_separator;
			mid_flags.held_is_s_type    = 1'b1;
			mid_flags.phrase_has_output = 1'b0;
		end else if (is_separator) begin
			if (!lone_mid) begin
				mid_slots[SlotHeld]   = 1'b1;
				mid_slots[SlotSepEnd] = 1'b1;
			end
			mid_flags.held_is_separator = 1'b1;
			mid_flags.held_is_s_type    = 1'b1;
			mid_flags.phrase_has_output = 1'b0;
		end else begin
			// Leftmost-S: held symbol is S and the new one is L.
			mid_slots[SlotCutEnd] = !sym_lt && !sym_eq && flags.held_is_s_type
				&& flags.phrase_has_output;
			mid_slots[SlotHeld]   = 1'b1;
			mid_flags.held_is_separator = 1'b0;
			mid_flags.held_is_s_type    = s_type;
			mid_flags.phrase_has_output = 1'b1;
		end
	end

	assign lone_end = drop_lone_separator && !mid_flags.phrase_has_output
		&& mid_flags.held_is_separator && before_is_boundary;

	always_comb begin
		next_flags       = mid_flags;
		next_held_symbol = symbol;
		if (last_of_range) begin
			next_flags       = FlagsReset;
			next_held_symbol = '0;
		end
	end

	// Flush slots are ORed in separately to keep the first block simple.
	logic [NumSlots-1:0] flush_slots;
	always_comb begin
		flush_slots = '0;
		if (last_of_range && !lone_end) begin
			flush_slots[SlotNew]      = 1'b1;
			flush_slots[SlotFlushEnd] = 1'b1;
		end
	end

	assign slots = mid_slots | flush_slots;

endmodule

// ===== rtl/lmsps_checker.sv =====
// ----------------------------------------------------------------------------
// lmsps_checker
// Port-level checks for the LMS phrase segmenter, bound to the top level.
// ----------------------------------------------------------------------------
`include "lms_phrase_segmenter_defines.svh"

module lmsps_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               item_ready,
	input logic               result_valid,
	input logic               result_ready,
	input lmsps_pkg::result_t result
);
	import lmsps_pkg::*;

	// Stalled result holds its transaction.
	`LMSPS_ASSERT_NEXT(a_result_hold, clk, arst_n, result_valid && !result_ready,
		result_valid && $stable(result))

	// End markers carry no symbol.
	`LMSPS_ASSERT_SAME(a_end_zero, clk, arst_n, result_valid && result.phrase_end,
		result.phrase_symbol == '0)

	// With nothing pending the block always takes input.
	`LMSPS_ASSERT_SAME(a_ready_when_empty, clk, arst_n, !result_valid, item_ready)

	// Input is blocked while a non-final result is still on show.
	`LMSPS_ASSERT_SAME(a_block_mid_item, clk, arst_n, result_valid && !result.last,
		!item_ready)

endmodule

bind lms_phrase_segmenter lmsps_checker u_lmsps_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.item_ready  (item_ready),
	.result_valid(result_valid),
	.result_ready(result_ready),
	.result      (result)
);
